FILE: hdl/binary_json_stream_validator_unit_macros.svh
// Assertion helpers for the files that check their own logic.
`ifndef BINARY_JSON_STREAM_VALIDATOR_UNIT_MACROS_SVH
`define BINARY_JSON_STREAM_VALIDATOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BJSV_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bjsv check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define BJSV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bjsv check failed one cycle later");

`endif

FILE: hdl/bjsv_pkg.sv
package bjsv_pkg;

    // Parser phases, one-hot.
    typedef enum logic [10:0] {
        PH_MAGIC = 11'b000_0000_0001,
        PH_HDR   = 11'b000_0000_0010,
        PH_LEN   = 11'b000_0000_0100,
        PH_F64   = 11'b000_0000_1000,
        PH_PAY   = 11'b000_0001_0000,
        PH_SIGN  = 11'b000_0010_0000,
        PH_KHDR  = 11'b000_0100_0000,
        PH_KLEN  = 11'b000_1000_0000,
        PH_KBYTE = 11'b001_0000_0000,
        PH_DONE  = 11'b010_0000_0000,
        PH_ERR   = 11'b100_0000_0000
    } phase_t;

    // Token classes reported per beat.
    localparam logic [3:0] TOK_MAGIC  = 4'd0;
    localparam logic [3:0] TOK_HDR    = 4'd1;
    localparam logic [3:0] TOK_LEN    = 4'd2;
    localparam logic [3:0] TOK_FLOAT  = 4'd3;
    localparam logic [3:0] TOK_PAY    = 4'd4;
    localparam logic [3:0] TOK_SIGN   = 4'd5;
    localparam logic [3:0] TOK_KHDR   = 4'd6;
    localparam logic [3:0] TOK_KLEN   = 4'd7;
    localparam logic [3:0] TOK_KBYTE  = 4'd8;

    // Value type nibbles.
    localparam logic [3:0] TYP_UNDEF  = 4'd1;
    localparam logic [3:0] TYP_BOOL   = 4'd2;
    localparam logic [3:0] TYP_NUMBER = 4'd3;
    localparam logic [3:0] TYP_STRING = 4'd4;
    localparam logic [3:0] TYP_BIGINT = 4'd5;
    localparam logic [3:0] TYP_BINARY = 4'd6;
    localparam logic [3:0] TYP_ARRAY  = 4'd7;
    localparam logic [3:0] TYP_OBJECT = 4'd8;
    localparam logic [3:0] TYP_DATE   = 4'd9;

    // Error codes.
    localparam logic [3:0] ERR_OK        = 4'd0;
    localparam logic [3:0] ERR_MAGIC     = 4'd1;
    localparam logic [3:0] ERR_LEN_WIDTH = 4'd2;
    localparam logic [3:0] ERR_SCALAR    = 4'd3;
    localparam logic [3:0] ERR_FLOAT     = 4'd4;
    localparam logic [3:0] ERR_BIGLEN    = 4'd5;
    localparam logic [3:0] ERR_SIGN      = 4'd6;
    localparam logic [3:0] ERR_BINARY    = 4'd7;
    localparam logic [3:0] ERR_COUNT     = 4'd8;
    localparam logic [3:0] ERR_KEY_HDR   = 4'd9;
    localparam logic [3:0] ERR_TYPE      = 4'd10;
    localparam logic [3:0] ERR_DEPTH     = 4'd11;
    localparam logic [3:0] ERR_TRUNC     = 4'd12;
    localparam logic [3:0] ERR_TRAILING  = 4'd13;

    localparam logic [3:0] NIBBLE_MASK = 4'hf;
    localparam logic [2:0] MAGIC_LEN   = 3'd5;

    // Container stack operations.
    typedef enum logic [1:0] {
        STK_NONE   = 2'd0,
        STK_PUSH   = 2'd1,
        STK_FINISH = 2'd2
    } stk_op_t;

    // What a finish or an open would do, seen from the stack side.
    typedef struct packed {
        logic fin_doc;
        logic fin_obj;
        logic fin_full;
        logic full;
        logic near_full;
    } stk_stat_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        logic [3:0] token_kind;
        logic [3:0] value_type;
        logic [9:0] nesting_depth;
        logic [7:0] data_byte;
        logic       item_done;
        logic       doc_done;
        logic [3:0] error_code;
    } out_t;

    // Expected magic byte at a given position.
    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] val;
        case (idx)
            3'd0:    val = 8'h43;
            3'd1:    val = 8'h4e;
            3'd2:    val = 8'h4f;
            3'd3:    val = 8'h43;
            3'd4:    val = 8'h01;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

FILE: hdl/binary_json_stream_validator_unit.sv
// Output: a byte's result beat is registered and presented in the cycle after the byte is accepted.
// Throughput: one byte per cycle while the output is not stalled; the parser, the registered top of the container
// stack and a prefetch of the next landing level let every beat go through without waiting on the stack.
// Reset: asynchronous, active low; the parser returns to the first magic byte and the
// stack empties at once. The stack memory itself is never cleared and needs no sweep.
`include "binary_json_stream_validator_unit_macros.svh"

module binary_json_stream_validator_unit #(
    parameter int MAX_DEPTH = 512
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  bjsv_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output bjsv_pkg::out_t out_data
);

    localparam int DW = $clog2(MAX_DEPTH + 1);

    bjsv_pkg::phase_t    phase_reg, ph_n;
    logic [2:0]          magic_idx_reg, mi_n;
    logic [63:0]         len_acc_reg, acc_n;
    logic [3:0]          len_left_reg, left_n;
    logic [63:0]         pay_left_reg, pay_n;
    logic [3:0]          cur_type_reg, ct_n;
    logic                sign_bad_reg, sb_n;
    logic [3:0]          err_reg, err_n;
    bjsv_pkg::out_t      out_reg, out_n;
    logic                out_valid_reg;

    bjsv_pkg::stk_op_t   op, op_step;
    bjsv_pkg::stk_stat_t stat;
    logic [DW-1:0]       depth;
    logic [DW+9:0]       depth_ext;
    logic                step;
    logic                do_open, do_finish, do_begin, raise;
    logic [3:0]          rcode, kind, vtype, tnib, anib;
    logic                item, doc;
    logic [7:0]          b;

    assign in_stall  = out_valid_reg && out_stall;
    assign step      = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign op_step   = step ? op : bjsv_pkg::STK_NONE;

    bjsv_stack #(.MAX_DEPTH(MAX_DEPTH)) u_stack (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op_step),
        .push_count (acc_n[31:0]),
        .push_obj   (cur_type_reg == bjsv_pkg::TYP_OBJECT),
        .stat       (stat),
        .depth      (depth)
    );

    assign b         = in_data.in_byte;
    assign tnib      = b[7:4];
    assign anib      = b[3:0] & bjsv_pkg::NIBBLE_MASK;
    assign depth_ext = {10'd0, depth};

    // Per-byte parse step.
    always_comb
    begin
        ph_n      = phase_reg;
        mi_n      = magic_idx_reg;
        acc_n     = len_acc_reg;
        left_n    = len_left_reg;
        pay_n     = pay_left_reg;
        ct_n      = cur_type_reg;
        sb_n      = sign_bad_reg;
        err_n     = err_reg;
        kind      = bjsv_pkg::TOK_MAGIC;
        vtype     = 4'd0;
        item      = 1'b0;
        doc       = 1'b0;
        op        = bjsv_pkg::STK_NONE;
        do_open   = 1'b0;
        do_finish = 1'b0;
        do_begin  = 1'b0;
        raise     = 1'b0;
        rcode     = bjsv_pkg::ERR_OK;

        case (phase_reg)
            bjsv_pkg::PH_MAGIC:
            begin
                if (magic_idx_reg >= bjsv_pkg::MAGIC_LEN
                    || b != bjsv_pkg::magic_byte(magic_idx_reg))
                begin
                    raise = 1'b1;
                    rcode = bjsv_pkg::ERR_MAGIC;
                end
                else
                begin
                    mi_n = magic_idx_reg + 3'd1;
                    if (mi_n == bjsv_pkg::MAGIC_LEN)
                    begin
                        do_begin = 1'b1;
                    end
                    else if (in_data.last_byte)
                    begin
                        raise = 1'b1;
                        rcode = bjsv_pkg::ERR_MAGIC;
                    end
                end
            end
            bjsv_pkg::PH_HDR:
            begin
                kind  = bjsv_pkg::TOK_HDR;
                vtype = tnib;
                ct_n  = tnib;
                if (tnib <= bjsv_pkg::TYP_UNDEF)
                begin
                    if (anib != 4'd0)
                    begin
                        raise = 1'b1;
                        rcode = bjsv_pkg::ERR_SCALAR;
                    end
                    else
                    begin
                        do_finish = 1'b1;
                    end
                end
                else if (tnib == bjsv_pkg::TYP_BOOL)
                begin
                    if (anib > 4'd1)
                    begin
                        raise = 1'b1;
                        rcode = bjsv_pkg::ERR_SCALAR;
                    end
                    else
                    begin
                        do_finish = 1'b1;
                    end
                end
                else if (tnib inside {bjsv_pkg::TYP_NUMBER, bjsv_pkg::TYP_DATE})
                begin
                    if (anib != 4'd8)
                    begin
                        raise = 1'b1;
                        rcode = bjsv_pkg::ERR_FLOAT;
                    end
                    else
                    begin
                        left_n = 4'd8;
                        ph_n   = bjsv_pkg::PH_F64;
                    end
                end
                else if (tnib inside {[bjsv_pkg::TYP_STRING:bjsv_pkg::TYP_OBJECT]})
                begin
                    if (anib == 4'd0 || anib > 4'd8)
                    begin
                        raise = 1'b1;
                        rcode = bjsv_pkg::ERR_LEN_WIDTH;
                    end
                    else
                    begin
                        left_n = anib;
                        acc_n  = '0;
                        ph_n   = bjsv_pkg::PH_LEN;
                    end
                end
                else
                begin
                    raise = 1'b1;
                    rcode = bjsv_pkg::ERR_TYPE;
                end
            end
            bjsv_pkg::PH_LEN:
            begin
                kind   = bjsv_pkg::TOK_LEN;
                vtype  = cur_type_reg;
                acc_n  = {len_acc_reg[55:0], b};
                left_n = len_left_reg - 4'd1;
                if (left_n == 4'd0)
                begin
                    if (cur_type_reg == bjsv_pkg::TYP_BIGINT)
                    begin
                        if (acc_n == '0)
                        begin
                            raise = 1'b1;
                            rcode = bjsv_pkg::ERR_BIGLEN;
                        end
                        else
                        begin
                            pay_n = acc_n;
                            ph_n  = bjsv_pkg::PH_SIGN;
                        end
                    end
                    else if (cur_type_reg inside {bjsv_pkg::TYP_ARRAY, bjsv_pkg::TYP_OBJECT})
                    begin
                        if (acc_n[63:32] != '0)
                        begin
                            raise = 1'b1;
                            rcode = bjsv_pkg::ERR_COUNT;
                        end
                        else
                        begin
                            do_open = 1'b1;
                        end
                    end
                    else if (cur_type_reg == bjsv_pkg::TYP_BINARY && acc_n[63:31] != '0)
                    begin
                        raise = 1'b1;
                        rcode = bjsv_pkg::ERR_BINARY;
                    end
                    else if (acc_n == '0)
                    begin
                        do_finish = 1'b1;
                    end
                    else
                    begin
                        pay_n = acc_n;
                        ph_n  = bjsv_pkg::PH_PAY;
                    end
                end
            end
            bjsv_pkg::PH_F64:
            begin
                kind   = bjsv_pkg::TOK_FLOAT;
                vtype  = cur_type_reg;
                left_n = len_left_reg - 4'd1;
                if (left_n == 4'd0)
                begin
                    do_finish = 1'b1;
                end
            end
            bjsv_pkg::PH_SIGN, bjsv_pkg::PH_PAY:
            begin
                kind  = (phase_reg == bjsv_pkg::PH_SIGN) ? bjsv_pkg::TOK_SIGN
                                                         : bjsv_pkg::TOK_PAY;
                vtype = cur_type_reg;
                if (phase_reg == bjsv_pkg::PH_SIGN)
                begin
                    sb_n = (b > 8'd1);
                end
                pay_n = pay_left_reg - 64'd1;
                if (pay_n == '0)
                begin
                    if (cur_type_reg == bjsv_pkg::TYP_BIGINT && sb_n)
                    begin
                        raise = 1'b1;
                        rcode = bjsv_pkg::ERR_SIGN;
                    end
                    else
                    begin
                        do_finish = 1'b1;
                    end
                end
                else
                begin
                    ph_n = bjsv_pkg::PH_PAY;
                end
            end
            bjsv_pkg::PH_KHDR:
            begin
                kind = bjsv_pkg::TOK_KHDR;
                if (tnib != 4'd0)
                begin
                    raise = 1'b1;
                    rcode = bjsv_pkg::ERR_KEY_HDR;
                end
                else if (anib == 4'd0 || anib > 4'd8)
                begin
                    raise = 1'b1;
                    rcode = bjsv_pkg::ERR_LEN_WIDTH;
                end
                else
                begin
                    left_n = anib;
                    acc_n  = '0;
                    ph_n   = bjsv_pkg::PH_KLEN;
                end
            end
            bjsv_pkg::PH_KLEN:
            begin
                kind   = bjsv_pkg::TOK_KLEN;
                acc_n  = {len_acc_reg[55:0], b};
                left_n = len_left_reg - 4'd1;
                if (left_n == 4'd0)
                begin
                    if (acc_n == '0)
                    begin
                        do_begin = 1'b1;
                    end
                    else
                    begin
                        pay_n = acc_n;
                        ph_n  = bjsv_pkg::PH_KBYTE;
                    end
                end
            end
            bjsv_pkg::PH_KBYTE:
            begin
                kind  = bjsv_pkg::TOK_KBYTE;
                pay_n = pay_left_reg - 64'd1;
                if (pay_n == '0)
                begin
                    do_begin = 1'b1;
                end
            end
            bjsv_pkg::PH_DONE:
            begin
                raise = 1'b1;
                rcode = bjsv_pkg::ERR_TRAILING;
            end
            default:
            begin
                raise = 1'b1;
                rcode = (err_reg != bjsv_pkg::ERR_OK) ? err_reg : bjsv_pkg::ERR_TYPE;
            end
        endcase

        // Opening a container: an empty one completes at once.
        if (do_open)
        begin
            if (acc_n == '0)
            begin
                do_finish = 1'b1;
            end
            else if (stat.full)
            begin
                raise = 1'b1;
                rcode = bjsv_pkg::ERR_DEPTH;
            end
            else
            begin
                op = bjsv_pkg::STK_PUSH;
                if (cur_type_reg == bjsv_pkg::TYP_OBJECT)
                begin
                    ph_n = bjsv_pkg::PH_KHDR;
                end
                else if (stat.near_full)
                begin
                    raise = 1'b1;
                    rcode = bjsv_pkg::ERR_DEPTH;
                end
                else
                begin
                    ph_n = bjsv_pkg::PH_HDR;
                end
            end
        end

        // Completing a value: close exhausted containers and pick the next step.
        if (do_finish)
        begin
            item = 1'b1;
            op   = bjsv_pkg::STK_FINISH;
            if (stat.fin_doc)
            begin
                doc  = 1'b1;
                ph_n = bjsv_pkg::PH_DONE;
            end
            else if (stat.fin_obj)
            begin
                ph_n = bjsv_pkg::PH_KHDR;
            end
            else if (stat.fin_full)
            begin
                raise = 1'b1;
                rcode = bjsv_pkg::ERR_DEPTH;
            end
            else
            begin
                ph_n = bjsv_pkg::PH_HDR;
            end
        end

        // A new value header follows.
        if (do_begin)
        begin
            if (stat.full)
            begin
                raise = 1'b1;
                rcode = bjsv_pkg::ERR_DEPTH;
            end
            else
            begin
                ph_n = bjsv_pkg::PH_HDR;
            end
        end

        // The first error sticks.
        if (raise)
        begin
            err_n = (err_reg != bjsv_pkg::ERR_OK) ? err_reg : rcode;
            ph_n  = bjsv_pkg::PH_ERR;
        end

        // Errors suppress completion marks; a final byte mid-value truncates.
        if (ph_n == bjsv_pkg::PH_ERR)
        begin
            item = 1'b0;
            doc  = 1'b0;
        end
        else if (in_data.last_byte && ph_n != bjsv_pkg::PH_DONE)
        begin
            err_n = (err_reg != bjsv_pkg::ERR_OK) ? err_reg : bjsv_pkg::ERR_TRUNC;
            ph_n  = bjsv_pkg::PH_ERR;
            item  = 1'b0;
            doc   = 1'b0;
        end

        out_n.token_kind    = kind;
        out_n.value_type    = vtype;
        out_n.nesting_depth = depth_ext[9:0];
        out_n.data_byte     = b;
        out_n.item_done     = item;
        out_n.doc_done      = doc;
        out_n.error_code    = err_n;
    end

    // Parser state advances on each accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= bjsv_pkg::PH_MAGIC;
            magic_idx_reg <= '0;
            len_acc_reg   <= '0;
            len_left_reg  <= '0;
            pay_left_reg  <= '0;
            cur_type_reg  <= '0;
            sign_bad_reg  <= 1'b0;
            err_reg       <= bjsv_pkg::ERR_OK;
        end
        else if (step)
        begin
            phase_reg     <= ph_n;
            magic_idx_reg <= mi_n;
            len_acc_reg   <= acc_n;
            len_left_reg  <= left_n;
            pay_left_reg  <= pay_n;
            cur_type_reg  <= ct_n;
            sign_bad_reg  <= sb_n;
            err_reg       <= err_n;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg <= out_n;
        end
    end

    // Checks on the parser.
    `BJSV_ASSERT_NEXT(a_err_sticky, clk, rst_n, err_reg != bjsv_pkg::ERR_OK, err_reg == $past(err_reg))
    `BJSV_ASSERT_SAME(a_err_phase, clk, rst_n, err_reg != bjsv_pkg::ERR_OK, phase_reg == bjsv_pkg::PH_ERR)
    `BJSV_ASSERT_SAME(a_doc_item, clk, rst_n, out_valid_reg && out_reg.doc_done, out_reg.item_done)

endmodule

FILE: hdl/bjsv_ram.sv
module bjsv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/bjsv_stack.sv
module bjsv_stack #(
    parameter int MAX_DEPTH = 512,
    localparam int DW = $clog2(MAX_DEPTH + 1),
    localparam int AW = $clog2(MAX_DEPTH)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bjsv_pkg::stk_op_t   op,
    input  logic [31:0]         push_count,
    input  logic                push_obj,
    output bjsv_pkg::stk_stat_t stat,
    output logic [DW-1:0]       depth
);

    // One stack level: elements left, object flag, and how many levels just
    // below it hold a single element left.
    typedef struct packed {
        logic [31:0]   cnt;
        logic          obj;
        logic [DW-1:0] below;
    } entry_t;

    localparam int EW = $bits(entry_t);

    entry_t        top_reg, top_next;
    entry_t        land_reg, land_next;
    entry_t        land_cur, src;
    logic          fresh_reg, fresh_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic [DW-1:0] run_reg, run_next;
    logic [DW-1:0] new_depth, new_run;
    logic [31:0]   new_cnt;
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [EW-1:0] rd_data;

    // The top level lives in registers; lower levels live in the memory.
    bjsv_ram #(.WIDTH(EW), .DEPTH(MAX_DEPTH)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (top_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The landing level is taken straight from the memory the cycle after its read.
    assign land_cur = fresh_reg ? entry_t'(rd_data) : land_reg;

    // Outcome of a finish or an open seen from the current state.
    always_comb
    begin
        stat.fin_doc   = (run_reg == depth_reg);
        stat.fin_obj   = (run_reg == '0) ? top_reg.obj : land_cur.obj;
        stat.full      = (depth_reg >= DW'(MAX_DEPTH));
        stat.near_full = (depth_reg >= DW'(MAX_DEPTH - 1));
        stat.fin_full  = (run_reg == '0) && stat.full;
    end

    assign depth = depth_reg;

    // Push writes the old top below the new one; finish pops the run of
    // single-element levels and fetches the next landing level.
    always_comb
    begin
        top_next   = top_reg;
        land_next  = land_cur;
        fresh_next = 1'b0;
        depth_next = depth_reg;
        run_next   = run_reg;
        wr_en      = 1'b0;
        wr_addr    = AW'(depth_reg - DW'(1));
        rd_en      = 1'b0;
        rd_addr    = '0;
        src        = (run_reg == '0) ? top_reg : land_cur;
        new_depth  = depth_reg - run_reg;
        new_cnt    = src.cnt - 32'd1;
        new_run    = src.below + DW'(1);
        case (op)
            bjsv_pkg::STK_PUSH:
            begin
                wr_en      = (depth_reg != '0);
                top_next   = '{cnt: push_count, obj: push_obj, below: run_reg};
                depth_next = depth_reg + DW'(1);
                if (push_count == 32'd1)
                begin
                    run_next = run_reg + DW'(1);
                    if (run_reg == '0)
                    begin
                        land_next = top_reg;
                    end
                end
                else
                begin
                    run_next = '0;
                end
            end
            bjsv_pkg::STK_FINISH:
            begin
                if (run_reg == depth_reg)
                begin
                    depth_next = '0;
                    run_next   = '0;
                end
                else
                begin
                    top_next   = '{cnt: new_cnt, obj: src.obj, below: src.below};
                    depth_next = new_depth;
                    if (new_cnt == 32'd1)
                    begin
                        run_next = new_run;
                        if (new_run < new_depth)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = AW'(new_depth - DW'(1) - new_run);
                            fresh_next = 1'b1;
                        end
                    end
                    else
                    begin
                        run_next = '0;
                    end
                end
            end
            default:
            begin
                top_next = top_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
            run_reg   <= '0;
            fresh_reg <= 1'b0;
        end
        else
        begin
            depth_reg <= depth_next;
            run_reg   <= run_next;
            fresh_reg <= fresh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg  <= top_next;
        land_reg <= land_next;
    end

endmodule

FILE: bench/testbench.sv
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH_LIMIT = 512;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_LEN    = 60;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_stall;
    bjsv_pkg::in_t  in_data;
    logic           out_valid;
    logic           out_stall;
    bjsv_pkg::out_t out_data;

    binary_json_stream_validator_unit #(.MAX_DEPTH(DEPTH_LIMIT)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // Pending bytes, their idle gaps, and the result beats still expected.
    bjsv_pkg::in_t    byte_queue[$];
    int               gap_queue[$];
    bjsv_pkg::out_t   expected_beats[$];

    // Predictor state.
    bjsv_pkg::phase_t ph = bjsv_pkg::PH_MAGIC;
    int               magic_pos = 0;
    logic [63:0]      len_acc = '0;
    int               len_left = 0;
    logic [63:0]      pay_left = '0;
    logic [3:0]       cur_type = '0;
    logic             sign_bad = 1'b0;
    int               depth = 0;
    logic [32:0]      levels[DEPTH_LIMIT];
    logic [3:0]       err_latch = bjsv_pkg::ERR_OK;

    int               errors = 0;
    int               cycles;
    int               beats_seen;
    int               docs_seen;
    int               hold_cycles;
    int               drain_at;
    bit               stim_done;

    // Raise an error, keeping the first one.
    task automatic set_err(input logic [3:0] code);
        if (err_latch == bjsv_pkg::ERR_OK)
            err_latch = code;
        ph = bjsv_pkg::PH_ERR;
    endtask

    task automatic start_value();
        if (depth >= DEPTH_LIMIT)
            set_err(bjsv_pkg::ERR_DEPTH);
        else
            ph = bjsv_pkg::PH_HDR;
    endtask

    // Close a value and walk up through containers that are now complete.
    task automatic close_value(inout logic item, inout logic doc);
        logic [31:0] cnt;
        item = 1'b1;
        forever
        begin
            if (depth == 0)
            begin
                doc = 1'b1;
                ph = bjsv_pkg::PH_DONE;
                return;
            end
            cnt = levels[depth - 1][31:0] - 32'd1;
            if (cnt == 32'd0)
            begin
                depth--;
                continue;
            end
            levels[depth - 1][31:0] = cnt;
            if (levels[depth - 1][32])
                ph = bjsv_pkg::PH_KHDR;
            else
                start_value();
            return;
        end
    endtask

    // Work out the result beat for one accepted byte.
    task automatic predict_beat(input bjsv_pkg::in_t b, output bjsv_pkg::out_t r);
        logic [3:0] t;
        logic [3:0] a;
        logic [3:0] kind;
        logic [3:0] vtype;
        logic       item;
        logic       doc;
        int         depth_in;
        t = b.in_byte[7:4];
        a = b.in_byte[3:0];
        kind = bjsv_pkg::TOK_MAGIC;
        vtype = 4'd0;
        item = 1'b0;
        doc = 1'b0;
        depth_in = depth;
        case (ph)
            bjsv_pkg::PH_MAGIC:
            begin
                if (magic_pos >= 5 || b.in_byte != bjsv_pkg::magic_byte(3'(magic_pos)))
                    set_err(bjsv_pkg::ERR_MAGIC);
                else
                begin
                    magic_pos++;
                    if (magic_pos == 5)
                        start_value();
                    else if (b.last_byte)
                        set_err(bjsv_pkg::ERR_MAGIC);
                end
            end
            bjsv_pkg::PH_HDR:
            begin
                kind = bjsv_pkg::TOK_HDR;
                vtype = t;
                cur_type = t;
                if (t <= bjsv_pkg::TYP_UNDEF)
                begin
                    if (a != 4'd0) set_err(bjsv_pkg::ERR_SCALAR);
                    else close_value(item, doc);
                end
                else if (t == bjsv_pkg::TYP_BOOL)
                begin
                    if (a > 4'd1) set_err(bjsv_pkg::ERR_SCALAR);
                    else close_value(item, doc);
                end
                else if (t == bjsv_pkg::TYP_NUMBER || t == bjsv_pkg::TYP_DATE)
                begin
                    if (a != 4'd8) set_err(bjsv_pkg::ERR_FLOAT);
                    else
                    begin
                        len_left = 8;
                        ph = bjsv_pkg::PH_F64;
                    end
                end
                else if (t >= bjsv_pkg::TYP_STRING && t <= bjsv_pkg::TYP_OBJECT)
                begin
                    if (a == 4'd0 || a > 4'd8) set_err(bjsv_pkg::ERR_LEN_WIDTH);
                    else
                    begin
                        len_left = int'(a);
                        len_acc = '0;
                        ph = bjsv_pkg::PH_LEN;
                    end
                end
                else
                    set_err(bjsv_pkg::ERR_TYPE);
            end
            bjsv_pkg::PH_LEN:
            begin
                kind = bjsv_pkg::TOK_LEN;
                vtype = cur_type;
                len_acc = {len_acc[55:0], b.in_byte};
                len_left--;
                if (len_left == 0)
                begin
                    if (cur_type == bjsv_pkg::TYP_BIGINT)
                    begin
                        if (len_acc == 64'd0) set_err(bjsv_pkg::ERR_BIGLEN);
                        else
                        begin
                            pay_left = len_acc;
                            ph = bjsv_pkg::PH_SIGN;
                        end
                    end
                    else if (cur_type == bjsv_pkg::TYP_ARRAY
                             || cur_type == bjsv_pkg::TYP_OBJECT)
                    begin
                        if (len_acc > 64'hffff_ffff) set_err(bjsv_pkg::ERR_COUNT);
                        else if (len_acc == 64'd0) close_value(item, doc);
                        else if (depth >= DEPTH_LIMIT) set_err(bjsv_pkg::ERR_DEPTH);
                        else
                        begin
                            levels[depth] = {cur_type == bjsv_pkg::TYP_OBJECT, len_acc[31:0]};
                            depth++;
                            if (cur_type == bjsv_pkg::TYP_OBJECT) ph = bjsv_pkg::PH_KHDR;
                            else start_value();
                        end
                    end
                    else if (cur_type == bjsv_pkg::TYP_BINARY && len_acc > 64'h7fff_ffff)
                        set_err(bjsv_pkg::ERR_BINARY);
                    else if (len_acc == 64'd0)
                        close_value(item, doc);
                    else
                    begin
                        pay_left = len_acc;
                        ph = bjsv_pkg::PH_PAY;
                    end
                end
            end
            bjsv_pkg::PH_F64:
            begin
                kind = bjsv_pkg::TOK_FLOAT;
                vtype = cur_type;
                len_left--;
                if (len_left == 0)
                    close_value(item, doc);
            end
            bjsv_pkg::PH_SIGN, bjsv_pkg::PH_PAY:
            begin
                kind = (ph == bjsv_pkg::PH_SIGN) ? bjsv_pkg::TOK_SIGN : bjsv_pkg::TOK_PAY;
                vtype = cur_type;
                if (ph == bjsv_pkg::PH_SIGN)
                    sign_bad = (b.in_byte > 8'd1);
                pay_left = pay_left - 64'd1;
                if (pay_left == 64'd0)
                begin
                    if (cur_type == bjsv_pkg::TYP_BIGINT && sign_bad)
                        set_err(bjsv_pkg::ERR_SIGN);
                    else
                        close_value(item, doc);
                end
                else
                    ph = bjsv_pkg::PH_PAY;
            end
            bjsv_pkg::PH_KHDR:
            begin
                kind = bjsv_pkg::TOK_KHDR;
                if (t != 4'd0) set_err(bjsv_pkg::ERR_KEY_HDR);
                else if (a == 4'd0 || a > 4'd8) set_err(bjsv_pkg::ERR_LEN_WIDTH);
                else
                begin
                    len_left = int'(a);
                    len_acc = '0;
                    ph = bjsv_pkg::PH_KLEN;
                end
            end
            bjsv_pkg::PH_KLEN:
            begin
                kind = bjsv_pkg::TOK_KLEN;
                len_acc = {len_acc[55:0], b.in_byte};
                len_left--;
                if (len_left == 0)
                begin
                    if (len_acc == 64'd0) start_value();
                    else
                    begin
                        pay_left = len_acc;
                        ph = bjsv_pkg::PH_KBYTE;
                    end
                end
            end
            bjsv_pkg::PH_KBYTE:
            begin
                kind = bjsv_pkg::TOK_KBYTE;
                pay_left = pay_left - 64'd1;
                if (pay_left == 64'd0)
                    start_value();
            end
            bjsv_pkg::PH_DONE:
                set_err(bjsv_pkg::ERR_TRAILING);
            default:
                set_err((err_latch != bjsv_pkg::ERR_OK) ? err_latch : bjsv_pkg::ERR_TYPE);
        endcase
        if (ph == bjsv_pkg::PH_ERR)
        begin
            item = 1'b0;
            doc = 1'b0;
        end
        else if (b.last_byte && ph != bjsv_pkg::PH_DONE)
        begin
            set_err(bjsv_pkg::ERR_TRUNC);
            item = 1'b0;
            doc = 1'b0;
        end
        r.token_kind = kind;
        r.value_type = vtype;
        r.nesting_depth = depth_in[9:0];
        r.data_byte = b.in_byte;
        r.item_done = item;
        r.doc_done = doc;
        r.error_code = err_latch;
    endtask

    // Stimulus helpers: queue bytes with random gaps.
    task automatic push_byte(input logic [7:0] v, input logic lst = 1'b0);
        bjsv_pkg::in_t b;
        b.in_byte = v;
        b.last_byte = lst;
        byte_queue.push_back(b);
        gap_queue.push_back((int'($urandom_range(0, 3)) == 0)
                            ? int'($urandom_range(0, 17)) : 0);
    endtask

    task automatic push_magic();
        for (int i = 0; i < 5; i++)
            push_byte(bjsv_pkg::magic_byte(3'(i)));
    endtask

    // Length field of given width carrying value v.
    task automatic push_len(input int w, input logic [63:0] v);
        for (int i = w - 1; i >= 0; i--)
            push_byte(v[i*8 +: 8]);
    endtask

    // A random well-formed value; lvl limits nesting.
    task automatic push_value(input int lvl);
        int t;
        int n;
        int w;
        t = int'($urandom_range(0, (lvl > 0) ? 9 : 7));
        if (t == 8 || t == 9) t = t + 1;
        case (t)
            0, 1: push_byte({t[3:0], 4'd0});
            2: push_byte({bjsv_pkg::TYP_BOOL, 3'd0, 1'($urandom_range(0, 1))});
            3, 4:
            begin
                push_byte({(t == 3) ? bjsv_pkg::TYP_NUMBER : bjsv_pkg::TYP_DATE, 4'd8});
                for (int i = 0; i < 8; i++) push_byte(8'($urandom));
            end
            5, 6:
            begin
                n = int'($urandom_range(0, 4));
                w = int'($urandom_range(1, 8));
                push_byte({(t == 5) ? bjsv_pkg::TYP_STRING : bjsv_pkg::TYP_BINARY, 4'(w)});
                push_len(w, 64'(n));
                for (int i = 0; i < n; i++) push_byte(8'($urandom));
            end
            9:
            begin
                n = int'($urandom_range(0, 3));
                w = int'($urandom_range(1, 8));
                push_byte({bjsv_pkg::TYP_ARRAY, 4'(w)});
                push_len(w, 64'(n));
                for (int i = 0; i < n; i++) push_value(lvl - 1);
            end
            10:
            begin
                n = int'($urandom_range(0, 3));
                w = int'($urandom_range(1, 2));
                push_byte({bjsv_pkg::TYP_OBJECT, 4'(w)});
                push_len(w, 64'(n));
                for (int i = 0; i < n; i++)
                begin
                    int k;
                    k = int'($urandom_range(0, 3));
                    w = int'($urandom_range(1, 8));
                    push_byte({4'd0, 4'(w)});
                    push_len(w, 64'(k));
                    for (int j = 0; j < k; j++) push_byte(8'($urandom));
                    push_value(lvl - 1);
                end
            end
            default:
            begin
                n = int'($urandom_range(1, 4));
                push_byte({bjsv_pkg::TYP_BIGINT, 4'd1});
                push_byte(8'(n));
                push_byte(8'($urandom_range(0, 1)));
                for (int i = 1; i < n; i++) push_byte(8'($urandom));
            end
        endcase
    endtask

    // Mark the final queued byte as the end of the buffer.
    task automatic mark_last();
        byte_queue[$].last_byte = 1'b1;
    endtask

    // Clock.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // One document: a top-level array holding directed and random elements,
    // followed by a tail of bytes that arrive after the document is complete.
    initial
    begin
        int elem_count;
        rst_n = 1'b0;
        drain_at = -1;
        push_magic();
        push_byte({bjsv_pkg::TYP_ARRAY, 4'd4});
        elem_count = 48;
        push_len(4, 64'(elem_count));
        // Directed elements: each type at its extremes.
        push_byte(8'h00);
        push_byte(8'h10);
        push_byte(8'h20);
        push_byte(8'h21);
        push_byte(8'h38);
        for (int i = 0; i < 8; i++) push_byte(8'hff);
        push_byte(8'h98);
        for (int i = 0; i < 8; i++) push_byte(8'h00);
        push_byte(8'h48);
        push_len(8, 64'd0);
        push_byte(8'h61);
        push_byte(8'h01);
        push_byte(8'hff);
        push_byte(8'h51);
        push_byte(8'h02);
        push_byte(8'h01);
        push_byte(8'h80);
        push_byte(8'h71);
        push_byte(8'h00);
        push_byte(8'h81);
        push_byte(8'h01);
        push_byte(8'h08);
        push_len(8, 64'd0);
        push_byte(8'h20);
        // Random elements fill the rest of the array.
        for (int i = 0; i < elem_count - 11; i++)
            push_value(3);
        // The sender waits for every result before the trailing tail.
        drain_at = byte_queue.size();
        push_byte(8'hf0);
        for (int i = 0; i < 20; i++) push_byte(8'($urandom));
        mark_last();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Driver: offers one queued byte at a time, honoring stall and random gaps.
    int  gap_left;
    int  sent;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            in_data   <= '0;
            gap_left  <= 0;
            sent      <= 0;
            stim_done <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                bjsv_pkg::out_t r;
                predict_beat(in_data, r);
                expected_beats.push_back(r);
            end
            if (!in_valid || !in_stall)
            begin
                if (byte_queue.size() == 0)
                begin
                    in_valid  <= 1'b0;
                    stim_done <= 1'b1;
                end
                else if (gap_left > 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (sent == drain_at && expected_beats.size() != 0)
                begin
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_valid <= 1'b1;
                    in_data  <= byte_queue.pop_front();
                    gap_left <= gap_queue.pop_front();
                    sent     <= sent + 1;
                end
            end
        end
    end

    // Long hold-off: once traffic is flowing, this counter times one long hold by the receiver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cycles <= 0;
        end
        else if (beats_seen > 20 && hold_cycles < HOLD_LEN)
        begin
            hold_cycles <= hold_cycles + 1;
        end
    end

    // Monitor: stalls at random and checks every accepted result beat.
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
            beats_seen <= 0;
            docs_seen  <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                bjsv_pkg::out_t e;
                beats_seen <= beats_seen + 1;
                if (out_data.doc_done) docs_seen <= docs_seen + 1;
                if (expected_beats.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    errors++;
                end
                else
                begin
                    e = expected_beats.pop_front();
                    if (out_data.token_kind != e.token_kind)
                    begin
                        $error("token_kind expected %0d actual %0d", e.token_kind,
                               out_data.token_kind);
                        errors++;
                    end
                    if (out_data.value_type != e.value_type)
                    begin
                        $error("value_type expected %0d actual %0d", e.value_type,
                               out_data.value_type);
                        errors++;
                    end
                    if (out_data.nesting_depth != e.nesting_depth)
                    begin
                        $error("nesting_depth expected %0d actual %0d", e.nesting_depth,
                               out_data.nesting_depth);
                        errors++;
                    end
                    if (out_data.data_byte != e.data_byte)
                    begin
                        $error("data_byte expected %0h actual %0h", e.data_byte,
                               out_data.data_byte);
                        errors++;
                    end
                    if (out_data.item_done != e.item_done)
                    begin
                        $error("item_done expected %0d actual %0d", e.item_done,
                               out_data.item_done);
                        errors++;
                    end
                    if (out_data.doc_done != e.doc_done)
                    begin
                        $error("doc_done expected %0d actual %0d", e.doc_done,
                               out_data.doc_done);
                        errors++;
                    end
                    if (out_data.error_code != e.error_code)
                    begin
                        $error("error_code expected %0d actual %0d", e.error_code,
                               out_data.error_code);
                        errors++;
                    end
                end
            end
            // The long hold-off takes priority over random stalls.
            if (beats_seen > 20 && hold_cycles < HOLD_LEN)
            begin
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else
            begin
                out_stall  <= 1'b0;
                stall_left <= (int'($urandom_range(0, 2)) == 0)
                              ? int'($urandom_range(0, 17)) : 0;
            end
        end
    end

    // End of run and timeout.
    initial
    begin
        cycles = 0;
        wait (rst_n);
        while (!(stim_done && expected_beats.size() == 0) && cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
        begin
            repeat (10) @(posedge clk);
            $display("Checked %0d result beats covering %0d finished document with every type,",
                     beats_seen, docs_seen);
            $display("then a tail of extra bytes that latched error code %0d.", err_latch);
            if (errors == 0)
                $display("Simulation PASSED");
            else
                $display("Simulation FAILED");
            $finish;
        end
    end

endmodule
